// ===== hw/rtl/button_press_repeat_detector_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Button repeat detector - assertion macros
// Shared concurrent assertion helpers for the detector RTL.
// ----------------------------------------------------------------------------
`ifndef BUTTON_PRESS_REPEAT_DETECTOR_UNIT_DEFINES_SVH
`define BUTTON_PRESS_REPEAT_DETECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BPRD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bprd same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BPRD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bprd next-cycle check failed");

`endif

// ===== hw/rtl/bprd_pkg.sv =====
// ----------------------------------------------------------------------------
// bprd_pkg
// Types and constants shared by the button repeat detector.
// ----------------------------------------------------------------------------
`default_nettype none

package bprd_pkg;

  localparam int TIME_W     = 32;  // millisecond timestamp
  localparam int INTERVAL_W = 16;  // repeat interval register
  localparam int LEVEL_W    = 6;   // button level field
  localparam int BIDX_W     = 3;   // button index field

  localparam logic [INTERVAL_W-1:0] REPEAT_RESET = 16'd750;

  // request into the shared time unit
  typedef struct packed {
    logic [TIME_W-1:0]     now;
    logic [TIME_W-1:0]     mark;
    logic [INTERVAL_W-1:0] interval;
  } arith_req_t;

  // response from the shared time unit
  typedef struct packed {
    logic              gt;   // (now - mark) mod 2^32 > interval
    logic [TIME_W-1:0] sum;  // mark + interval
  } arith_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bprd_if.sv =====
// ----------------------------------------------------------------------------
// bprd_if
// Valid/ready channel interfaces for poll ticks and button events.
// ----------------------------------------------------------------------------
`default_nettype none

interface bprd_in_if import bprd_pkg::*;;
  logic               valid;
  logic               ready;
  logic [TIME_W-1:0]  now_ms;
  logic [LEVEL_W-1:0] button_levels;

  modport source (output valid, output now_ms, output button_levels, input ready);
  modport sink   (input valid, input now_ms, input button_levels, output ready);
endinterface

interface bprd_out_if import bprd_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BIDX_W-1:0] button_index;
  logic              is_repeat;
  logic              last_event;

  modport source (output valid, output button_index, output is_repeat,
                  output last_event, input ready);
  modport sink   (input valid, input button_index, input is_repeat,
                  input last_event, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/button_press_repeat_detector_unit.sv =====
// ----------------------------------------------------------------------------
// button_press_repeat_detector_unit
// Keypad press and auto-repeat detector: turns poll ticks into button events.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      transaction payload
//  in_chan   in   valid/ready    now_ms[31:0], button_levels[5:0]
//  out_chan  out  valid/ready    button_index[2:0], is_repeat, last_event
//  cfg_*     in   write enable   cfg_wdata[15:0] -> repeat interval (ms)
//
//  A tick is accepted, then the buttons are scanned one per cycle through the
//  shared subtract/compare/add unit, then the events are emitted one per cycle
//  while out is ready, and a closing step returns the sequencer to idle.
//  in_chan.ready is high only while the sequencer is idle.
//  Output stalls hold the event register; the drain waits on out_chan.ready.
//  rst_n is synchronous: all buttons released, interval back to 750 ms.
// ----------------------------------------------------------------------------
`default_nettype none

module button_press_repeat_detector_unit import bprd_pkg::*; #(
  parameter int NUM_BUTTONS = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bprd_in_if.sink               in_chan,
  bprd_out_if.source            out_chan,
  input  logic                  cfg_we,
  input  logic [INTERVAL_W-1:0] cfg_wdata
);

  // Repeat interval register. User must write it only while idle; not enforced.
  // Zero is used as is (repeats each tick whose time differs from the mark).
  logic [INTERVAL_W-1:0] interval_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= REPEAT_RESET;
    end else if (cfg_we) begin
      interval_r <= cfg_wdata;
    end
  end

  // Sequencer with per-button state, shared time unit and event register.
  bprd_seq #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .interval  (interval_r),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_now    (in_chan.now_ms),
    .in_levels (in_chan.button_levels),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_index (out_chan.button_index),
    .out_rep   (out_chan.is_repeat),
    .out_last  (out_chan.last_event)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/bprd_unit.sv =====
// ----------------------------------------------------------------------------
// bprd_unit
// Shared time unit: elapsed-time compare and mark advance for one button.
// ----------------------------------------------------------------------------
`default_nettype none

module bprd_unit import bprd_pkg::*; (
  input  arith_req_t req,
  output arith_rsp_t rsp
);

  logic [TIME_W-1:0] elapsed;
  logic [TIME_W-1:0] ivl_ext;

  assign ivl_ext = TIME_W'(req.interval);
  assign elapsed = req.now - req.mark;  // wraps mod 2^32

  assign rsp.gt  = (elapsed > ivl_ext);
  assign rsp.sum = req.mark + ivl_ext;

endmodule

`default_nettype wire

// ===== hw/rtl/bprd_seq.sv =====
// ----------------------------------------------------------------------------
// bprd_seq
// Sequencer: scans buttons one per cycle through the shared time unit,
// then drains the collected events through the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "button_press_repeat_detector_unit_defines.svh"

module bprd_seq import bprd_pkg::*; #(
  parameter int NUM_BUTTONS = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [INTERVAL_W-1:0] interval,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [TIME_W-1:0]     in_now,
  input  logic [LEVEL_W-1:0]    in_levels,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [BIDX_W-1:0]     out_index,
  output logic                  out_rep,
  output logic                  out_last
);

  localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUTTONS - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } seq_state_t;

  seq_state_t state_r, state_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [NUM_BUTTONS-1:0] prev_r, prev_nxt;
  logic [NUM_BUTTONS-1:0] held_r, held_nxt;
  logic [NUM_BUTTONS-1:0] rep_r, rep_nxt;
  logic [NUM_BUTTONS-1:0] ev_r, ev_nxt;        // pending event per button
  logic [NUM_BUTTONS-1:0] evrep_r, evrep_nxt;  // pending event is a repeat
  logic                   out_valid_r, out_valid_nxt;

  logic [NUM_BUTTONS-1:0] lev_r;
  logic [TIME_W-1:0]      now_r;
  logic [TIME_W-1:0]      mark_r [NUM_BUTTONS];
  logic [BIDX_W-1:0]      out_index_r;
  logic                   out_rep_r;
  logic                   out_last_r;

  logic [NUM_BUTTONS-1:0] lev_in;
  logic                   accept;
  logic                   mark_we;
  logic [TIME_W-1:0]      mark_wd;
  logic                   load;
  logic [IDX_W-1:0]       low_sel;
  logic [NUM_BUTTONS-1:0] ev_rest;

  arith_req_t req;
  arith_rsp_t rsp;

  // level bits above the field width read as released
  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lev
    if (g < LEVEL_W) begin : g_on
      assign lev_in[g] = in_levels[g];
    end else begin : g_off
      assign lev_in[g] = 1'b0;
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  assign req.now      = now_r;
  assign req.mark     = mark_r[idx_r];
  assign req.interval = interval;

  bprd_unit u_unit (
    .req (req),
    .rsp (rsp)
  );

  // lowest pending event
  always_comb begin
    low_sel = '0;
    for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
      if (ev_r[i]) begin
        low_sel = IDX_W'(i);
      end
    end
  end

  assign ev_rest = ev_r & (ev_r - 1'b1);
  assign load    = (state_r == ST_EMIT) && (ev_r != '0) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    prev_nxt      = prev_r;
    held_nxt      = held_r;
    rep_nxt       = rep_r;
    ev_nxt        = ev_r;
    evrep_nxt     = evrep_r;
    mark_we       = 1'b0;
    mark_wd       = now_r;
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SCAN;
          idx_nxt   = '0;
        end
      end
      ST_SCAN: begin
        if (lev_r[idx_r] != prev_r[idx_r]) begin
          if (lev_r[idx_r]) begin
            // press: start a new hold
            held_nxt[idx_r] = 1'b1;
            rep_nxt[idx_r]  = 1'b0;
            mark_we         = 1'b1;
            mark_wd         = now_r;
          end else begin
            // release: plain press unless repeats went out
            ev_nxt[idx_r]    = !rep_r[idx_r];
            evrep_nxt[idx_r] = 1'b0;
            held_nxt[idx_r]  = 1'b0;
            rep_nxt[idx_r]   = 1'b0;
          end
        end else if (held_r[idx_r] && rsp.gt) begin
          mark_we          = 1'b1;
          mark_wd          = rsp.sum;
          rep_nxt[idx_r]   = 1'b1;
          ev_nxt[idx_r]    = 1'b1;
          evrep_nxt[idx_r] = 1'b1;
        end
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_EMIT;
          prev_nxt  = lev_r;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_EMIT: begin
        if (ev_r == '0) begin
          state_nxt = ST_IDLE;
        end else if (load) begin
          ev_nxt        = ev_rest;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      prev_r      <= '0;
      held_r      <= '0;
      rep_r       <= '0;
      ev_r        <= '0;
      evrep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      prev_r      <= prev_nxt;
      held_r      <= held_nxt;
      rep_r       <= rep_nxt;
      ev_r        <= ev_nxt;
      evrep_r     <= evrep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      now_r <= in_now;
      lev_r <= lev_in;
    end
    if (mark_we) begin
      mark_r[idx_r] <= mark_wd;
    end
    if (load) begin
      out_index_r <= BIDX_W'(low_sel);
      out_rep_r   <= evrep_r[low_sel];
      out_last_r  <= (ev_rest == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_index = out_index_r;
  assign out_rep   = out_rep_r;
  assign out_last  = out_last_r;

  `BPRD_ASSERT_NOW(a_idle_no_pending, clk, rst_n, state_r == ST_IDLE, ev_r == '0)
  `BPRD_ASSERT_NEXT(a_scan_to_emit, clk, rst_n, (state_r == ST_SCAN) && (idx_r == LAST_IDX), state_r == ST_EMIT)
  `BPRD_ASSERT_NEXT(a_last_drains, clk, rst_n, load && (ev_rest == '0), (ev_r == '0) && out_valid_r && out_last_r)
  `BPRD_ASSERT_NOW(a_state_onehot, clk, rst_n, 1'b1, $onehot(state_r))

endmodule

`default_nettype wire
